/* rtl/sdbs_pkg.sv */
// Shared types and constants for the sorted dictionary search block.
`default_nettype none

package sdbs_pkg;

  localparam int WORD_W      = 128;
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_QUERY = 1'b1
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [15:0] entry_index;
    logic [63:0] word_high;
    logic [63:0] word_low;
  } item_t;

  typedef struct packed {
    logic        found;
    logic [15:0] last_probe;
  } result_t;

  // Classified work handed from the front to the back.
  typedef struct packed {
    op_t               op;
    logic [15:0]       index;
    logic [WORD_W-1:0] word;
  } entry_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_PROBE,
    BK_CHECK
  } back_state_t;

endpackage

`default_nettype wire

/* rtl/sdbs_ram.sv */
// Generic single-port RAM with registered read.
`default_nettype none

module sdbs_ram #(
  parameter int WIDTH = 128,
  parameter int DEPTH = 65536,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    addr,
  input  wire logic [WIDTH-1:0] wdata,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

/* rtl/sdbs_front.sv */
// Front end: accepts items, masks word bytes and drops out-of-range writes.
`default_nettype none

module sdbs_front #(
  parameter int DICT_DEPTH = 65536,
  parameter int WORD_BYTES = 16
) (
  input  wire logic          start,
  input  wire logic          full,
  input  wire sdbs_pkg::item_t item,
  output logic               push,
  output sdbs_pkg::entry_t   entry
);
  import sdbs_pkg::*;

  localparam logic [WORD_W-1:0] WORD_MASK = ~({WORD_W{1'b1}} >> (8 * WORD_BYTES));

  logic in_range;
  logic accept;

  assign accept   = start && !full;
  assign in_range = 32'(item.entry_index) < 32'(DICT_DEPTH);

  always_comb begin
    entry.op    = item.op;
    entry.index = item.entry_index;
    entry.word  = {item.word_high, item.word_low} & WORD_MASK;
    // drop writes past the end of the store: they have no effect
    push        = accept && ((item.op == OP_QUERY) || in_range);
  end

endmodule

`default_nettype wire

/* rtl/sdbs_queue.sv */
// Short FIFO between front and back.
`default_nettype none

module sdbs_queue #(
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire sdbs_pkg::entry_t push_data,
  input  wire logic             pop,
  output sdbs_pkg::entry_t      head,
  output logic                  full,
  output logic                  empty
);
  import sdbs_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  entry_t           slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W:0]   count;

  assign full  = count == (PTR_W + 1)'(DEPTH);
  assign empty = count == '0;
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + (PTR_W + 1)'(1);
      end else if (pop && !push) begin
        count <= count - (PTR_W + 1)'(1);
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/sdbs_back.sv */
// Back end: performs writes and runs the binary search over the RAM.
`default_nettype none

module sdbs_back #(
  parameter int DICT_DEPTH = 65536
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic [16:0]      entry_count,
  input  wire sdbs_pkg::entry_t head,
  input  wire logic             empty,
  output logic                  pop,
  output logic                  done,
  output sdbs_pkg::result_t     result
);
  import sdbs_pkg::*;

  localparam int AW = (DICT_DEPTH > 1) ? $clog2(DICT_DEPTH) : 1;
  localparam int CW = $clog2(DICT_DEPTH + 1);

  back_state_t       state, state_next;
  logic [CW-1:0]     lo, lo_next;
  logic [CW-1:0]     hi, hi_next;
  logic [CW-1:0]     probe, probe_next;
  logic [WORD_W-1:0] key, key_next;
  logic              done_next;
  result_t           result_next;

  logic [CW-1:0]     count_clamp;
  logic [CW:0]       sum;
  logic [CW-1:0]     mid;
  logic [CW+15:0]    probe_ext;
  logic [AW+15:0]    index_ext;
  logic [31:0]       count_wide;

  logic              ram_we;
  logic [AW-1:0]     ram_addr;
  logic [WORD_W-1:0] ram_rdata;

  sdbs_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DICT_DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (head.word),
    .rdata (ram_rdata)
  );

  assign count_wide  = {15'b0, entry_count};
  assign count_clamp = (count_wide > 32'(DICT_DEPTH)) ? CW'(DICT_DEPTH) : count_wide[CW-1:0];
  assign sum         = {1'b0, lo} + {1'b0, hi} - (CW + 1)'(1);
  assign mid         = sum[CW:1];
  assign probe_ext   = {16'b0, probe};
  assign index_ext   = {{AW{1'b0}}, head.index};

  always_comb begin
    state_next  = state;
    lo_next     = lo;
    hi_next     = hi;
    probe_next  = probe;
    key_next    = key;
    done_next   = 1'b0;
    result_next = result;
    pop         = 1'b0;
    ram_we      = 1'b0;
    ram_addr    = probe[AW-1:0];
    case (state)
      BK_IDLE: begin
        if (!empty) begin
          pop = 1'b1;
          if (head.op == OP_WRITE) begin
            ram_we   = 1'b1;
            ram_addr = index_ext[AW-1:0];
          end else begin
            key_next   = head.word;
            lo_next    = '0;
            hi_next    = count_clamp;
            probe_next = '0;
            state_next = BK_PROBE;
          end
        end
      end
      BK_PROBE: begin
        if (lo < hi) begin
          ram_addr   = mid[AW-1:0];
          probe_next = mid;
          state_next = BK_CHECK;
        end else begin
          // search exhausted: miss
          done_next              = 1'b1;
          result_next.found      = 1'b0;
          result_next.last_probe = probe_ext[15:0];
          state_next             = BK_IDLE;
        end
      end
      BK_CHECK: begin
        if (ram_rdata == key) begin
          done_next              = 1'b1;
          result_next.found      = 1'b1;
          result_next.last_probe = probe_ext[15:0];
          state_next             = BK_IDLE;
        end else if (ram_rdata < key) begin
          lo_next    = probe + CW'(1);
          state_next = BK_PROBE;
        end else begin
          hi_next    = probe;
          state_next = BK_PROBE;
        end
      end
      default: begin
        state_next = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    lo     <= lo_next;
    hi     <= hi_next;
    probe  <= probe_next;
    key    <= key_next;
    result <= result_next;
  end

endmodule

`default_nettype wire

/* rtl/sorted_dictionary_binary_search.sv */
// Sorted dictionary membership search: top level.
// Queries take P probes (at most log2 of the entry count plus one) on the single RAM port;
// the back end takes no new item until the current query has its result, and a write is
// performed as it is popped in the idle state. busy is high while the two-entry queue is full.
// Synchronous reset clears the queue, the search state and entry_count; the RAM is not cleared.
`default_nettype none

module sorted_dictionary_binary_search #(
  parameter int DICT_DEPTH = 65536,
  parameter int WORD_BYTES = 16
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  output logic                   busy,
  input  wire sdbs_pkg::item_t   item,
  output logic                   done,
  output sdbs_pkg::result_t      result,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [16:0]       cfg_data
);
  import sdbs_pkg::*;

  logic [16:0] entry_count;
  logic        push;
  entry_t      push_data;
  entry_t      head;
  logic        full;
  logic        empty;
  logic        pop;

  assign cfg_ready = 1'b1;
  assign busy      = full;

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
    end else if (cfg_valid && cfg_ready) begin
      entry_count <= cfg_data;
    end
  end

  sdbs_front #(
    .DICT_DEPTH (DICT_DEPTH),
    .WORD_BYTES (WORD_BYTES)
  ) u_front (
    .start (start),
    .full  (full),
    .item  (item),
    .push  (push),
    .entry (push_data)
  );

  sdbs_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .full      (full),
    .empty     (empty)
  );

  sdbs_back #(
    .DICT_DEPTH (DICT_DEPTH)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .entry_count (entry_count),
    .head        (head),
    .empty       (empty),
    .pop         (pop),
    .done        (done),
    .result      (result)
  );

endmodule

`default_nettype wire

/* rtl/sdbs_checker.sv */
// Port-level checks for the dictionary search block, bound to the top level.
`default_nettype none

module sdbs_checker (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              start,
  input wire logic              busy,
  input wire logic              done,
  input wire sdbs_pkg::result_t result,
  input wire logic              cfg_valid,
  input wire logic              cfg_ready
);

  // a search needs at least one probe state between results
  a_no_back_to_back_done: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result beat on two consecutive cycles");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> (!done && !busy))
    else $error("result or busy after reset");

  // the queue fills only from an accepted beat
  a_busy_from_start: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start))
    else $error("busy rose without a start beat");

  a_cfg_always_ready: assert property (@(posedge clk) disable iff (rst)
    cfg_valid |-> cfg_ready)
    else $error("configuration write stalled");

  a_result_known: assert property (@(posedge clk) disable iff (rst)
    done |-> !$isunknown(result))
    else $error("result beat carries unknown bits");

endmodule

bind sorted_dictionary_binary_search sdbs_checker u_sdbs_checker (.*);

`default_nettype wire
